// ----- rtl/modbus_rtu_read_pair_master_top_macros.svh -----
// Assertion helpers for the read pair master.
`ifndef MODBUS_RTU_READ_PAIR_MASTER_TOP_MACROS_SVH
`define MODBUS_RTU_READ_PAIR_MASTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define MBRTU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MBRTU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MBRTU_ASSERT(label, clk, rst_n, prop, msg)
`define MBRTU_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- rtl/mbrtu_pkg.sv -----
package mbrtu_pkg;

    localparam int CFG_INDEX_W = 1;

    typedef enum logic [1:0] {
        FUNC_START   = 2'd0,
        FUNC_RX_BYTE = 2'd1,
        FUNC_TICK    = 2'd2
    } func_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TIMEOUT_TICKS  = 1'd0,
        CFG_START_REGISTER = 1'd1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TIMEOUT   = 3'd1,
        ST_CRC       = 3'd2,
        ST_ADDRESS   = 3'd3,
        ST_EXCEPTION = 3'd4,
        ST_FUNCTION  = 3'd5,
        ST_COUNT     = 3'd6,
        ST_ZERO_PAIR = 3'd7
    } status_t;

    typedef enum logic [0:0] {
        KIND_REQUEST = 1'b0,
        KIND_OUTCOME = 1'b1
    } kind_t;

    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [7:0]  FN_READ           = 8'h03;
    localparam int          EXC_FLAG_BIT      = 7;
    localparam logic [15:0] READ_REG_COUNT    = 16'h0002;
    localparam logic [7:0]  EXPECT_BYTE_COUNT = 8'h04;
    localparam logic [3:0]  RESP_LEN          = 4'd9;
    localparam logic [15:0] TIMEOUT_RESET     = 16'd200;
    localparam logic [15:0] START_REG_RESET   = 16'h0300;

    typedef struct packed {
        logic               kind;
        logic [7:0]         tx_data;
        logic               last;
        logic [2:0]         status;
        logic [7:0]         exception_code;
        logic signed [15:0] temperature_tenths;
        logic [15:0]        humidity_tenths;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/mbrtu_if.sv -----
interface mbrtu_in_if import mbrtu_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] slave_address;
    logic [7:0] rx_data;

    modport source (output valid, output func, output slave_address, output rx_data,
                    input ready);
    modport sink (input valid, input func, input slave_address, input rx_data,
                  output ready);
endinterface

interface mbrtu_out_if import mbrtu_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [7:0]         tx_data;
    logic               last;
    logic [2:0]         status;
    logic [7:0]         exception_code;
    logic signed [15:0] temperature_tenths;
    logic [15:0]        humidity_tenths;

    modport source (output valid, output kind, output tx_data, output last, output status,
                    output exception_code, output temperature_tenths,
                    output humidity_tenths, input ready);
    modport sink (input valid, input kind, input tx_data, input last, input status,
                  input exception_code, input temperature_tenths,
                  input humidity_tenths, output ready);
endinterface

interface mbrtu_cfg_if import mbrtu_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [15:0]            data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/modbus_rtu_read_pair_master_top.sv -----
// Modbus RTU master for one read of two holding registers. A start transfer emits the
// eight request bytes, one per cycle while the result buffer has room, and the input stalls
// until the last of them is emitted; received bytes and ticks are otherwise taken one per
// cycle while the result buffer has room. Results go through a two-entry buffer, so input
// keeps flowing while a result waits. The ninth response byte or a timeout tick yields one
// outcome. No clearing pass after reset; configuration writes are always accepted.
`include "modbus_rtu_read_pair_master_top_macros.svh"

module modbus_rtu_read_pair_master_top import mbrtu_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    mbrtu_in_if.sink     item,
    mbrtu_out_if.source  result,
    mbrtu_cfg_if.sink    cfg
);

    logic [15:0] timeout_ticks_reg, timeout_ticks_next;
    logic [15:0] start_register_reg, start_register_next;
    logic        waiting_reg, waiting_next;
    logic [3:0]  bytes_received_reg, bytes_received_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic [7:0]  expected_address_reg, expected_address_next;
    logic [15:0] elapsed_ticks_reg, elapsed_ticks_next;
    logic        emit_busy_reg, emit_busy_next;
    logic [2:0]  emit_idx_reg, emit_idx_next;
    logic [15:0] tx_crc_reg, tx_crc_next;
    logic [1:0]  count_reg, count_next;
    logic [7:0]  frame_bytes_reg [8];
    result_t     slot_reg [2];
    result_t     slot_next [2];

    logic        item_fire, pop, space, emit_push, outcome_push, push;
    logic        frame_we;
    logic [7:0]  emit_byte;
    logic [15:0] elapsed_inc, temp_raw, hum_raw;
    logic        write_idx;
    result_t     emit_res, outcome_res, push_data;

    assign cfg.ready    = 1'b1;
    assign pop          = (count_reg != 2'd0) && result.ready;
    assign space        = (count_reg != 2'd2) || pop;
    assign item.ready   = !emit_busy_reg && space;
    assign item_fire    = item.valid && item.ready;
    assign emit_push    = emit_busy_reg && space;
    assign push         = emit_push || outcome_push;
    assign push_data    = emit_busy_reg ? emit_res : outcome_res;
    assign write_idx    = 1'((count_reg - {1'b0, pop}));
    assign elapsed_inc  = (elapsed_ticks_reg == 16'hFFFF) ? elapsed_ticks_reg
                                                          : elapsed_ticks_reg + 16'd1;
    assign temp_raw     = {frame_bytes_reg[3], frame_bytes_reg[4]};
    assign hum_raw      = {frame_bytes_reg[5], frame_bytes_reg[6]};

    assign result.valid              = count_reg != 2'd0;
    assign result.kind               = slot_reg[0].kind;
    assign result.tx_data            = slot_reg[0].tx_data;
    assign result.last               = slot_reg[0].last;
    assign result.status             = slot_reg[0].status;
    assign result.exception_code     = slot_reg[0].exception_code;
    assign result.temperature_tenths = slot_reg[0].temperature_tenths;
    assign result.humidity_tenths    = slot_reg[0].humidity_tenths;

    always_comb
    begin
        unique case (emit_idx_reg)
            3'd0:    emit_byte = expected_address_reg;
            3'd1:    emit_byte = FN_READ;
            3'd2:    emit_byte = start_register_reg[15:8];
            3'd3:    emit_byte = start_register_reg[7:0];
            3'd4:    emit_byte = READ_REG_COUNT[15:8];
            3'd5:    emit_byte = READ_REG_COUNT[7:0];
            3'd6:    emit_byte = tx_crc_reg[7:0];
            default: emit_byte = tx_crc_reg[15:8];
        endcase
        emit_res                    = '0;
        emit_res.kind               = KIND_REQUEST;
        emit_res.tx_data            = emit_byte;
        emit_res.last               = emit_idx_reg == 3'd7;
    end

    always_comb
    begin
        timeout_ticks_next    = timeout_ticks_reg;
        start_register_next   = start_register_reg;
        waiting_next          = waiting_reg;
        bytes_received_next   = bytes_received_reg;
        running_crc_next      = running_crc_reg;
        expected_address_next = expected_address_reg;
        elapsed_ticks_next    = elapsed_ticks_reg;
        emit_busy_next        = emit_busy_reg;
        emit_idx_next         = emit_idx_reg;
        tx_crc_next           = tx_crc_reg;
        frame_we              = 1'b0;
        outcome_push          = 1'b0;
        outcome_res           = '0;
        outcome_res.kind      = KIND_OUTCOME;

        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_TIMEOUT_TICKS:  timeout_ticks_next  = cfg.data;
                CFG_START_REGISTER: start_register_next = cfg.data;
                default:            ;
            endcase
        end

        if (emit_push)
        begin
            if (emit_idx_reg < 3'd6)
            begin
                tx_crc_next = crc_byte(tx_crc_reg, emit_byte);
            end
            emit_idx_next = emit_idx_reg + 3'd1;
            if (emit_idx_reg == 3'd7)
            begin
                emit_busy_next = 1'b0;
            end
        end

        if (item_fire)
        begin
            unique case (item.func)
                FUNC_START:
                begin
                    waiting_next          = 1'b1;
                    bytes_received_next   = 4'd0;
                    running_crc_next      = CRC_INIT;
                    expected_address_next = item.slave_address;
                    elapsed_ticks_next    = 16'd0;
                    emit_busy_next        = 1'b1;
                    emit_idx_next         = 3'd0;
                    tx_crc_next           = CRC_INIT;
                end
                FUNC_RX_BYTE:
                begin
                    if (waiting_reg && bytes_received_reg < RESP_LEN)
                    begin
                        if (bytes_received_reg < 4'd8)
                        begin
                            frame_we = 1'b1;
                            if (bytes_received_reg < 4'd7)
                            begin
                                running_crc_next = crc_byte(running_crc_reg, item.rx_data);
                            end
                            bytes_received_next = bytes_received_reg + 4'd1;
                        end
                        else
                        begin
                            bytes_received_next = RESP_LEN;
                            waiting_next        = 1'b0;
                            outcome_push        = 1'b1;
                            priority if ({item.rx_data, frame_bytes_reg[7]} != running_crc_reg)
                            begin
                                outcome_res.status = ST_CRC;
                            end
                            else if (frame_bytes_reg[0] != expected_address_reg)
                            begin
                                outcome_res.status = ST_ADDRESS;
                            end
                            else if (frame_bytes_reg[1] != FN_READ)
                            begin
                                if (frame_bytes_reg[1][EXC_FLAG_BIT])
                                begin
                                    outcome_res.status         = ST_EXCEPTION;
                                    outcome_res.exception_code = frame_bytes_reg[2];
                                end
                                else
                                begin
                                    outcome_res.status = ST_FUNCTION;
                                end
                            end
                            else if (frame_bytes_reg[2] != EXPECT_BYTE_COUNT)
                            begin
                                outcome_res.status = ST_COUNT;
                            end
                            else if (temp_raw == 16'd0 && hum_raw == 16'd0)
                            begin
                                outcome_res.status = ST_ZERO_PAIR;
                            end
                            else
                            begin
                                outcome_res.status             = ST_OK;
                                outcome_res.temperature_tenths = $signed(temp_raw);
                                outcome_res.humidity_tenths    = hum_raw;
                            end
                        end
                    end
                end
                FUNC_TICK:
                begin
                    if (waiting_reg)
                    begin
                        elapsed_ticks_next = elapsed_inc;
                        if (elapsed_inc >= timeout_ticks_reg)
                        begin
                            waiting_next       = 1'b0;
                            outcome_push       = 1'b1;
                            outcome_res.status = ST_TIMEOUT;
                        end
                    end
                end
                default: ;
            endcase
        end

        count_next   = count_reg + {1'b0, push} - {1'b0, pop};
        slot_next[0] = pop ? slot_reg[1] : slot_reg[0];
        slot_next[1] = slot_reg[1];
        if (push)
        begin
            slot_next[write_idx] = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg    <= TIMEOUT_RESET;
            start_register_reg   <= START_REG_RESET;
            waiting_reg          <= 1'b0;
            bytes_received_reg   <= 4'd0;
            running_crc_reg      <= CRC_INIT;
            expected_address_reg <= 8'd0;
            elapsed_ticks_reg    <= 16'd0;
            emit_busy_reg        <= 1'b0;
            emit_idx_reg         <= 3'd0;
            tx_crc_reg           <= CRC_INIT;
            count_reg            <= 2'd0;
        end
        else
        begin
            timeout_ticks_reg    <= timeout_ticks_next;
            start_register_reg   <= start_register_next;
            waiting_reg          <= waiting_next;
            bytes_received_reg   <= bytes_received_next;
            running_crc_reg      <= running_crc_next;
            expected_address_reg <= expected_address_next;
            elapsed_ticks_reg    <= elapsed_ticks_next;
            emit_busy_reg        <= emit_busy_next;
            emit_idx_reg         <= emit_idx_next;
            tx_crc_reg           <= tx_crc_next;
            count_reg            <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            frame_bytes_reg[bytes_received_reg[2:0]] <= item.rx_data;
        end
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

    `MBRTU_ASSERT(a_start_arms, clk, rst_n, item_fire && item.func == FUNC_START |=> emit_busy_reg && waiting_reg, "start transfer did not arm request emission")
    `MBRTU_ASSERT(a_emit_ends, clk, rst_n, emit_push && emit_idx_reg == 3'd7 |=> !emit_busy_reg, "request emission ran past last byte")
    `MBRTU_ASSERT(a_outcome_waiting, clk, rst_n, outcome_push |-> waiting_reg && !emit_busy_reg, "outcome raised while not waiting")
    `MBRTU_ASSERT_ALWAYS(a_rx_count_bound, clk, !rst_n || (bytes_received_reg <= RESP_LEN && count_reg != 2'd3), "receive count or result buffer out of range")

endmodule

// ----- tb/sv/modbus_rtu_read_pair_master_top_tb.sv -----
`timescale 1ns / 1ps

module modbus_rtu_read_pair_master_top_tb;
    import mbrtu_pkg::*;

    localparam logic [1:0] FUNC_UNUSED    = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         SETTLE_CYCLES  = 20;
    localparam int         MAX_PRINTED    = 40;
    localparam int         TICK_ODDS      = 12;

    typedef struct {
        logic [1:0] func;
        logic [7:0] addr;
        logic [7:0] rx;
    } bus_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mbrtu_in_if  item_bus ();
    mbrtu_out_if result_bus ();
    mbrtu_cfg_if cfg_bus ();

    logic                   in_valid = 1'b0;
    logic [1:0]             in_func = FUNC_TICK;
    logic [7:0]             in_addr = 8'h00;
    logic [7:0]             in_rx = 8'h00;
    logic                   out_ready = 1'b0;
    logic                   wr_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] wr_index = '0;
    logic [15:0]            wr_data = '0;

    assign item_bus.valid         = in_valid;
    assign item_bus.func          = in_func;
    assign item_bus.slave_address = in_addr;
    assign item_bus.rx_data       = in_rx;
    assign result_bus.ready       = out_ready;
    assign cfg_bus.valid          = wr_valid;
    assign cfg_bus.index          = wr_index;
    assign cfg_bus.data           = wr_data;

    modbus_rtu_read_pair_master_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    always #10 clk = ~clk;

    bus_item_t   pending_items [$];
    result_t     due_results [$];
    int          items_queued = 0;
    int          items_taken = 0;
    int          results_seen = 0;
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    bit          burst = 1'b0;
    logic [15:0] timeout_set = TIMEOUT_RESET;

    // mirror of the master
    logic        rd_waiting;
    logic [3:0]  rd_count;
    logic [15:0] rd_crc;
    logic [7:0]  rd_addr;
    logic [7:0]  rd_frame [8];
    logic [15:0] rd_ticks;
    logic [15:0] reg_timeout;
    logic [15:0] rd_start;

    // data bits folded in one at a time; same result as xor-then-shift
    function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] data);
        logic [15:0] r;
        r = acc;
        for (int k = 0; k < 8; k++)
        begin
            if (r[0] ^ data[k])
                r = (r >> 1) ^ CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    function automatic result_t make_result(input kind_t k, input logic [7:0] tx, input logic l,
                                            input status_t s, input logic [7:0] e,
                                            input logic [15:0] tp, input logic [15:0] hm);
        result_t r;
        r.kind               = k;
        r.tx_data            = tx;
        r.last               = l;
        r.status             = s;
        r.exception_code     = e;
        r.temperature_tenths = tp;
        r.humidity_tenths    = hm;
        return r;
    endfunction

    task automatic step_master(input logic [1:0] f, input logic [7:0] a, input logic [7:0] b);
        logic [7:0]  req [8];
        logic [15:0] c;
        logic [15:0] t;
        logic [15:0] h;
        logic [7:0]  exc;
        status_t     st;
        case (f)
            FUNC_START:
            begin
                req[0] = a;
                req[1] = FN_READ;
                req[2] = rd_start[15:8];
                req[3] = rd_start[7:0];
                req[4] = READ_REG_COUNT[15:8];
                req[5] = READ_REG_COUNT[7:0];
                c = CRC_INIT;
                for (int i = 0; i < 6; i++)
                    c = crc16_update(c, req[i]);
                req[6] = c[7:0];
                req[7] = c[15:8];
                for (int i = 0; i < 8; i++)
                    due_results.push_back(make_result(KIND_REQUEST, req[i], i == 7, ST_OK,
                                                      8'h00, 16'h0000, 16'h0000));
                rd_waiting = 1'b1;
                rd_count   = 4'd0;
                rd_crc     = CRC_INIT;
                rd_addr    = a;
                rd_ticks   = 16'd0;
            end
            FUNC_RX_BYTE:
            begin
                if (rd_waiting && rd_count < RESP_LEN)
                begin
                    if (rd_count < 4'd8)
                    begin
                        rd_frame[rd_count[2:0]] = b;
                        if (rd_count < 4'd7)
                            rd_crc = crc16_update(rd_crc, b);
                        rd_count = rd_count + 4'd1;
                    end
                    else
                    begin
                        rd_count   = RESP_LEN;
                        rd_waiting = 1'b0;
                        exc = 8'h00;
                        t   = 16'h0000;
                        h   = 16'h0000;
                        if ({b, rd_frame[7]} != rd_crc)
                            st = ST_CRC;
                        else if (rd_frame[0] != rd_addr)
                            st = ST_ADDRESS;
                        else if (rd_frame[1] != FN_READ)
                        begin
                            if (rd_frame[1][EXC_FLAG_BIT])
                            begin
                                st  = ST_EXCEPTION;
                                exc = rd_frame[2];
                            end
                            else
                                st = ST_FUNCTION;
                        end
                        else if (rd_frame[2] != EXPECT_BYTE_COUNT)
                            st = ST_COUNT;
                        else if ({rd_frame[3], rd_frame[4], rd_frame[5], rd_frame[6]} == 32'd0)
                            st = ST_ZERO_PAIR;
                        else
                        begin
                            st = ST_OK;
                            t  = {rd_frame[3], rd_frame[4]};
                            h  = {rd_frame[5], rd_frame[6]};
                        end
                        due_results.push_back(make_result(KIND_OUTCOME, 8'h00, 1'b0, st, exc, t, h));
                    end
                end
            end
            FUNC_TICK:
            begin
                if (rd_waiting)
                begin
                    if (rd_ticks != 16'hFFFF)
                        rd_ticks = rd_ticks + 16'd1;
                    if (rd_ticks >= reg_timeout)
                    begin
                        rd_waiting = 1'b0;
                        due_results.push_back(make_result(KIND_OUTCOME, 8'h00, 1'b0, ST_TIMEOUT,
                                                          8'h00, 16'h0000, 16'h0000));
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_error(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("mismatch at result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got, input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 80)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk)
    begin
        if ($urandom_range(0, 149) == 0)
            burst <= ~burst;
    end

    // driver
    always @(posedge clk)
    begin
        bus_item_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !item_bus.ready)
        begin
        end
        else if (gap_left > 0)
        begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_items.size() > 0)
        begin
            nxt = pending_items.pop_front();
            in_valid <= 1'b1;
            in_func  <= nxt.func;
            in_addr  <= nxt.addr;
            in_rx    <= nxt.rx;
            gap_left <= pick_gap();
        end
        else
            in_valid <= 1'b0;
    end

    // monitor: config mirror, prediction, result check, result-side stalls
    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            stall_left  <= 0;
            rd_waiting  = 1'b0;
            rd_count    = 4'd0;
            rd_crc      = CRC_INIT;
            rd_addr     = 8'h00;
            rd_ticks    = 16'd0;
            reg_timeout = TIMEOUT_RESET;
            rd_start    = START_REG_RESET;
        end
        else
        begin
            if (wr_valid && cfg_bus.ready)
            begin
                case (cfg_index_t'(wr_index))
                    CFG_TIMEOUT_TICKS:  reg_timeout = wr_data;
                    CFG_START_REGISTER: rd_start = wr_data;
                    default: ;
                endcase
            end
            if (in_valid && item_bus.ready)
            begin
                step_master(in_func, in_addr, in_rx);
                items_taken++;
            end
            if (result_bus.valid && out_ready)
            begin
                if (due_results.size() == 0)
                    report_error("result transfer with nothing expected");
                else
                begin
                    want = due_results.pop_front();
                    compare_field("kind", 16'(result_bus.kind), 16'(want.kind));
                    compare_field("tx_data", 16'(result_bus.tx_data), 16'(want.tx_data));
                    compare_field("last", 16'(result_bus.last), 16'(want.last));
                    compare_field("status", 16'(result_bus.status), 16'(want.status));
                    compare_field("exception_code", 16'(result_bus.exception_code),
                                  16'(want.exception_code));
                    compare_field("temperature_tenths", result_bus.temperature_tenths,
                                  want.temperature_tenths);
                    compare_field("humidity_tenths", result_bus.humidity_tenths,
                                  want.humidity_tenths);
                end
                results_seen++;
            end
            if (stall_left > 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_ready  <= 1'b1;
                stall_left <= pick_stall();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && item_bus.ready) || (result_bus.valid && out_ready)
            || (wr_valid && cfg_bus.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic push_item(input logic [1:0] f, input logic [7:0] a, input logic [7:0] b);
        bus_item_t it;
        it.func = f;
        it.addr = a;
        it.rx   = b;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic push_start(input logic [7:0] a);
        push_item(FUNC_START, a, 8'($urandom_range(0, 255)));
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_item(FUNC_RX_BYTE, 8'($urandom_range(0, 255)), b);
    endtask

    task automatic push_tick();
        push_item(FUNC_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic push_noise(input int n);
        repeat (n)
            push_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
    endtask

    task automatic push_reply(input logic [7:0] a, input logic [7:0] fn, input logic [7:0] cnt,
                              input logic [15:0] w1, input logic [15:0] w2,
                              input logic [15:0] flip, input int tick_odds);
        logic [7:0]  frame [9];
        logic [15:0] c;
        frame[0] = a;
        frame[1] = fn;
        frame[2] = cnt;
        frame[3] = w1[15:8];
        frame[4] = w1[7:0];
        frame[5] = w2[15:8];
        frame[6] = w2[7:0];
        c = CRC_INIT;
        for (int i = 0; i < 7; i++)
            c = crc16_update(c, frame[i]);
        c = c ^ flip;
        frame[7] = c[7:0];
        frame[8] = c[15:8];
        for (int i = 0; i < 9; i++)
        begin
            if (tick_odds > 0 && $urandom_range(0, tick_odds - 1) == 0)
                push_tick();
            push_byte(frame[i]);
        end
    endtask

    function automatic logic [7:0] pick_addr();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic push_exchange();
        logic [7:0]  a;
        logic [7:0]  fn;
        logic [7:0]  cnt;
        int          flavour;
        a = pick_addr();
        flavour = $urandom_range(0, 12);
        if ($urandom_range(0, 4) == 0)
            push_noise($urandom_range(1, 3));
        push_start(a);
        case (flavour)
            4: push_reply(a, FN_READ, EXPECT_BYTE_COUNT, pick_word(), pick_word(),
                          16'($urandom_range(1, 65535)), TICK_ODDS);
            5: push_reply(a ^ 8'($urandom_range(1, 255)), FN_READ, EXPECT_BYTE_COUNT,
                          pick_word(), pick_word(), 16'h0000, TICK_ODDS);
            6:
            begin
                fn = 8'h80 | 8'($urandom_range(0, 127));
                push_reply(a, fn, 8'($urandom_range(0, 255)), pick_word(), pick_word(),
                           16'h0000, TICK_ODDS);
            end
            7:
            begin
                fn = 8'($urandom_range(0, 127));
                if (fn == FN_READ)
                    fn = 8'h00;
                push_reply(a, fn, EXPECT_BYTE_COUNT, pick_word(), pick_word(), 16'h0000,
                           TICK_ODDS);
            end
            8:
            begin
                cnt = 8'($urandom_range(0, 255));
                if (cnt == EXPECT_BYTE_COUNT)
                    cnt = 8'h05;
                push_reply(a, FN_READ, cnt, pick_word(), pick_word(), 16'h0000, TICK_ODDS);
            end
            9: push_reply(a, FN_READ, EXPECT_BYTE_COUNT, 16'h0000, 16'h0000, 16'h0000,
                          TICK_ODDS);
            10:
            begin
                if (timeout_set <= 16'd64)
                begin
                    repeat ((timeout_set == 16'd0) ? 1 : timeout_set)
                        push_tick();
                    if ($urandom_range(0, 1) == 0)
                        push_noise($urandom_range(1, 3));
                end
                else
                    repeat ($urandom_range(0, 8))
                        push_byte(8'($urandom_range(0, 255)));
            end
            11:
                repeat ($urandom_range(1, 8))
                    push_byte(8'($urandom_range(0, 255)));
            12:
            begin
                push_reply(a, FN_READ, EXPECT_BYTE_COUNT, pick_word(), pick_word(), 16'h0000,
                           TICK_ODDS);
                push_noise($urandom_range(1, 3));
            end
            default: push_reply(a, FN_READ, EXPECT_BYTE_COUNT, pick_word(), pick_word(),
                                16'h0000, TICK_ODDS);
        endcase
    endtask

    task automatic wait_idle();
        while (items_taken != items_queued || due_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // a clean read closes every phase so the master is idle for the next writes
    task automatic run_phase(input int budget);
        int first;
        logic [7:0] a;
        first = items_queued;
        while (items_queued - first < budget)
            push_exchange();
        a = pick_addr();
        push_start(a);
        push_reply(a, FN_READ, EXPECT_BYTE_COUNT, pick_word(), pick_word(), 16'h0000, 0);
        wait_idle();
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] v);
        @(posedge clk);
        wr_valid <= 1'b1;
        wr_index <= idx;
        wr_data  <= v;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        wr_valid <= 1'b0;
        if (idx == CFG_TIMEOUT_TICKS)
            timeout_set = v;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // idle traffic is dropped
        push_item(FUNC_TICK, 8'hAA, 8'h55);
        push_item(FUNC_RX_BYTE, 8'h55, 8'hAA);
        push_item(FUNC_UNUSED, 8'hFF, 8'hFF);
        push_start(8'hFF);
        push_reply(8'hFF, FN_READ, EXPECT_BYTE_COUNT, 16'h8000, 16'hFFFF, 16'h0000, 0);
        // restart mid-response, then a zero pair and a byte past the ninth
        push_start(8'h00);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h03);
        push_start(8'h01);
        push_reply(8'h01, FN_READ, EXPECT_BYTE_COUNT, 16'h0000, 16'h0000, 16'h0000, 0);
        push_byte(8'hFF);
        wait_idle();

        write_reg(CFG_TIMEOUT_TICKS, 16'd1);
        write_reg(CFG_START_REGISTER, 16'hFFFF);
        push_start(8'h7E);
        push_tick();
        push_byte(8'h7E);
        run_phase(25);

        write_reg(CFG_TIMEOUT_TICKS, 16'd0);
        write_reg(CFG_START_REGISTER, 16'h0000);
        push_start(8'h80);
        push_tick();
        run_phase(25);

        write_reg(CFG_TIMEOUT_TICKS, 16'hFFFF);
        write_reg(CFG_START_REGISTER, 16'($urandom_range(0, 65535)));
        run_phase(25);

        write_reg(CFG_TIMEOUT_TICKS, 16'($urandom_range(2, 40)));
        write_reg(CFG_START_REGISTER, 16'($urandom_range(0, 65535)));
        run_phase(25);

        write_reg(CFG_TIMEOUT_TICKS, TIMEOUT_RESET);
        write_reg(CFG_START_REGISTER, START_REG_RESET);
        run_phase(25);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mbrtu_pkg.sv
rtl/mbrtu_if.sv
rtl/modbus_rtu_read_pair_master_top.sv
tb/sv/modbus_rtu_read_pair_master_top_tb.sv
